>>> rtl/nidma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nidma_pkg
// Shared types, codes and helpers of the network interface dma unit.
// ----------------------------------------------------------------------------
package nidma_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned WORD_BYTES  = 4;
    localparam int unsigned CMD_W       = 3;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 168;

    localparam logic [WORD_W-1:0] STAT_TX      = 32'd1;
    localparam logic [WORD_W-1:0] STAT_READING = 32'd4;
    localparam logic [WORD_W-1:0] STAT_DONE    = 32'd5;
    localparam logic [WORD_W-1:0] RX_SIZE_INIT = 32'h0000_00FF;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADDR_WRITE   = 3'd0,
        CMD_ADDR_READ    = 3'd1,
        CMD_STATUS_WRITE = 3'd2,
        CMD_STATUS_READ  = 3'd3,
        CMD_ROUTER_FLOW  = 3'd4,
        CMD_TICK         = 3'd5,
        CMD_FLIT         = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2,
        MODE_WAIT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        FIELD_HEADER  = 2'd0,
        FIELD_SIZE    = 2'd1,
        FIELD_PAYLOAD = 2'd2
    } t_field;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] wdata;
        logic              router_go;
        logic [WORD_W-1:0] mem_rdata;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] rdata;
        logic              flit_valid;
        logic [WORD_W-1:0] flit_data;
        logic              mem_write;
        logic [WORD_W-1:0] mem_address;
        logic [WORD_W-1:0] mem_data;
        logic [WORD_W-1:0] read_address;
        logic              ready_to_receive;
        logic              irq;
        logic              iterate_request;
        logic              error;
    } t_result;

    function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] x);
        swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [WORD_W-1:0] mode_status(input t_mode m);
        mode_status = swap32({30'd0, m});
    endfunction

endpackage

>>> rtl/noc_network_interface_dma_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noc_network_interface_dma_unit
// Network interface with dma between a processor bus and a mesh router.
// ----------------------------------------------------------------------------
//  port group  | dir | beat contents
//  s_axis      | in  | tuser: cmd; tdata: wdata, router_go, mem_rdata
//  m_axis      | out | tdata: one result per command beat
//
//  each beat waits in the input register, the engine handles it in one pass
//  of combinational logic and it lands in the output register at the next edge
//  from s_axis acceptance to m_axis valid a beat passes the input and output
//  registers in turn; one beat per cycle sustained while m_axis_tready is high
//  a stalled m_axis freezes the engine; s_axis still takes one beat into the
//  empty input register; synchronous active-low reset clears both valid flags
//  and, but for the receive remaining count, the engine state
// ----------------------------------------------------------------------------
module noc_network_interface_dma_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] wdata, [32] router_go, [64:33] mem_rdata, [71:65] unused
    input  logic [nidma_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [2:0] cmd
    input  logic [nidma_pkg::CMD_W-1:0]            s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [31:0] rdata, [32] flit_valid, [64:33] flit_data, [65] mem_write,
    // [97:66] mem_address, [129:98] mem_data, [161:130] read_address,
    // [162] ready_to_receive, [163] irq, [164] iterate_request, [165] error,
    // [167:166] zero
    output logic [nidma_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import nidma_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_result;
    logic    w_advance;
    logic    w_fire;
    logic    w_take;
    t_result w_result;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_item.cmd       <= s_axis_tuser;
            r_in_item.wdata     <= s_axis_tdata[31:0];
            r_in_item.router_go <= s_axis_tdata[32];
            r_in_item.mem_rdata <= s_axis_tdata[64:33];
        end
    end

    nidma_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00,
                            r_out_result.error,
                            r_out_result.iterate_request,
                            r_out_result.irq,
                            r_out_result.ready_to_receive,
                            r_out_result.read_address,
                            r_out_result.mem_data,
                            r_out_result.mem_address,
                            r_out_result.mem_write,
                            r_out_result.flit_data,
                            r_out_result.flit_valid,
                            r_out_result.rdata};

endmodule

>>> rtl/nidma_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nidma_engine
// Interface state and combinational command handling for one beat.
// ----------------------------------------------------------------------------
module nidma_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  nidma_pkg::t_item   i_item,
    output nidma_pkg::t_result o_result
);
    import nidma_pkg::*;

    t_mode             r_mode, n_mode;
    logic              r_base_known, n_base_known;
    logic [WORD_W-1:0] r_receive_base, n_receive_base;
    logic [WORD_W-1:0] r_receive_pointer, n_receive_pointer;
    t_field            r_receive_field, n_receive_field;
    logic [WORD_W-1:0] r_receive_remaining, n_receive_remaining;
    logic [WORD_W-1:0] r_transmit_pointer, n_transmit_pointer;
    t_field            r_transmit_field, n_transmit_field;
    logic [WORD_W-1:0] r_transmit_remaining, n_transmit_remaining;
    logic [WORD_W-1:0] r_pending_address, n_pending_address;
    logic              r_router_ready, n_router_ready;
    logic              r_local_ready, n_local_ready;
    logic              r_interrupt_level, n_interrupt_level;
    logic [WORD_W-1:0] r_status_word, n_status_word;
    logic [WORD_W-1:0] r_address_word, n_address_word;

    logic [WORD_W-1:0] w_status_cmd;
    logic              w_tx_go;
    t_result           w_res;

    assign w_status_cmd = swap32(i_item.wdata);

    always_comb begin
        n_mode               = r_mode;
        n_base_known         = r_base_known;
        n_receive_base       = r_receive_base;
        n_receive_pointer    = r_receive_pointer;
        n_receive_field      = r_receive_field;
        n_receive_remaining  = r_receive_remaining;
        n_transmit_pointer   = r_transmit_pointer;
        n_transmit_field     = r_transmit_field;
        n_transmit_remaining = r_transmit_remaining;
        n_pending_address    = r_pending_address;
        n_router_ready       = r_router_ready;
        n_local_ready        = r_local_ready;
        n_interrupt_level    = r_interrupt_level;
        n_status_word        = r_status_word;
        n_address_word       = r_address_word;
        w_tx_go              = 1'b0;
        w_res                = '0;

        case (t_cmd'(i_item.cmd))
            CMD_ADDR_WRITE: begin
                if (!r_base_known) begin
                    n_receive_base = swap32(i_item.wdata);
                    n_base_known   = 1'b1;
                    n_mode         = MODE_IDLE;
                    n_status_word  = mode_status(MODE_IDLE);
                end else begin
                    n_pending_address = swap32(i_item.wdata);
                    n_local_ready     = 1'b0;
                end
                n_address_word = i_item.wdata;
            end
            CMD_ADDR_READ: begin
                w_res.rdata = r_address_word;
            end
            CMD_STATUS_WRITE: begin
                if (w_status_cmd == STAT_TX) begin
                    if (r_mode != MODE_IDLE) begin
                        w_res.error = 1'b1;
                    end else begin
                        n_mode             = MODE_TX;
                        n_local_ready      = 1'b0;
                        n_transmit_pointer = r_pending_address;
                        n_transmit_field   = FIELD_HEADER;
                        w_tx_go            = 1'b1;
                    end
                end else if (w_status_cmd == STAT_READING) begin
                    if (r_mode != MODE_RX) begin
                        w_res.error = 1'b1;
                    end else begin
                        n_mode            = MODE_WAIT;
                        n_local_ready     = 1'b0;
                        n_interrupt_level = 1'b0;
                    end
                end else if (w_status_cmd == STAT_DONE) begin
                    if (r_mode != MODE_WAIT) begin
                        w_res.error = 1'b1;
                    end else begin
                        n_mode        = MODE_IDLE;
                        n_local_ready = 1'b1;
                    end
                end
            end
            CMD_STATUS_READ: begin
                w_res.iterate_request = 1'b1;
                w_res.rdata           = r_status_word;
            end
            CMD_ROUTER_FLOW: begin
                n_router_ready = i_item.router_go;
            end
            CMD_TICK: begin
                w_tx_go = 1'b1;
            end
            CMD_FLIT: begin
                if (r_mode == MODE_IDLE) begin
                    n_mode              = MODE_RX;
                    n_status_word       = mode_status(MODE_RX);
                    n_receive_pointer   = r_receive_base;
                    n_receive_field     = FIELD_HEADER;
                    n_receive_remaining = RX_SIZE_INIT;
                    n_local_ready       = 1'b1;
                end
                if (n_mode == MODE_RX) begin
                    case (n_receive_field)
                        FIELD_HEADER: n_receive_field = FIELD_SIZE;
                        FIELD_SIZE: begin
                            n_receive_field     = FIELD_PAYLOAD;
                            n_receive_remaining = swap32(i_item.wdata);
                        end
                        default: n_receive_remaining = n_receive_remaining - 32'd1;
                    endcase
                    w_res.mem_write   = 1'b1;
                    w_res.mem_address = n_receive_pointer;
                    w_res.mem_data    = i_item.wdata;
                    n_receive_pointer = n_receive_pointer + WORD_W'(WORD_BYTES);
                end
                if (n_receive_remaining == '0) begin
                    n_local_ready     = 1'b0;
                    n_interrupt_level = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // transmit one word on a tick or transmit start in tx mode when the router lets us
        if (w_tx_go && n_mode == MODE_TX && r_router_ready) begin
            w_res.flit_valid = 1'b1;
            w_res.flit_data  = i_item.mem_rdata;
            case (n_transmit_field)
                FIELD_HEADER: n_transmit_field = FIELD_SIZE;
                FIELD_SIZE: begin
                    n_transmit_field     = FIELD_PAYLOAD;
                    n_transmit_remaining = swap32(i_item.mem_rdata);
                end
                default: n_transmit_remaining = n_transmit_remaining - 32'd1;
            endcase
            n_transmit_pointer = n_transmit_pointer + WORD_W'(WORD_BYTES);
            if (n_transmit_field == FIELD_PAYLOAD && n_transmit_remaining == '0) begin
                n_mode        = MODE_IDLE;
                n_status_word = mode_status(MODE_IDLE);
                n_local_ready = 1'b1;
            end
        end

        if (t_cmd'(i_item.cmd) == CMD_STATUS_WRITE && !w_res.error) begin
            n_status_word = i_item.wdata;
        end

        w_res.read_address     = (n_mode == MODE_TX) ? n_transmit_pointer : n_pending_address;
        w_res.ready_to_receive = n_local_ready;
        w_res.irq              = n_interrupt_level;
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode               <= MODE_IDLE;
            r_base_known         <= 1'b0;
            r_receive_base       <= '0;
            r_receive_pointer    <= '0;
            r_receive_field      <= FIELD_HEADER;
            r_transmit_pointer   <= '0;
            r_transmit_field     <= FIELD_HEADER;
            r_transmit_remaining <= '0;
            r_pending_address    <= '0;
            r_router_ready       <= 1'b1;
            r_local_ready        <= 1'b0;
            r_interrupt_level    <= 1'b0;
            r_status_word        <= '0;
            r_address_word       <= '0;
        end else if (i_fire) begin
            r_mode               <= n_mode;
            r_base_known         <= n_base_known;
            r_receive_base       <= n_receive_base;
            r_receive_pointer    <= n_receive_pointer;
            r_receive_field      <= n_receive_field;
            r_transmit_pointer   <= n_transmit_pointer;
            r_transmit_field     <= n_transmit_field;
            r_transmit_remaining <= n_transmit_remaining;
            r_pending_address    <= n_pending_address;
            r_router_ready       <= n_router_ready;
            r_local_ready        <= n_local_ready;
            r_interrupt_level    <= n_interrupt_level;
            r_status_word        <= n_status_word;
            r_address_word       <= n_address_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_receive_remaining <= n_receive_remaining;
        end
    end

    a_err_no_side_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_res.error |-> !w_res.flit_valid && !w_res.mem_write && n_mode == r_mode)
        else $error("rejected command changed the interface");

    a_rx_pointer_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_res.mem_write
        |=> r_receive_pointer == $past(w_res.mem_address) + WORD_W'(WORD_BYTES))
        else $error("receive pointer did not advance by one word");

    a_irq_clear_by_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_interrupt_level && !n_interrupt_level
        |-> t_cmd'(i_item.cmd) == CMD_STATUS_WRITE && r_mode == MODE_RX)
        else $error("interrupt dropped without a reading command");

    a_base_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base_known |=> r_base_known)
        else $error("receive base lost");

endmodule
